>>> sv/fpr_pkg.sv
// Package with the shared constants, codes and the CRC-8 step of the framed packet receiver.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // Framing bytes.
  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'hBB;
  localparam logic [7:0] NO_STUFF   = 8'hFF;

  // Item commands.
  localparam logic [1:0] CMD_POLL = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_CONT   = 3'd0;
  localparam logic [2:0] ST_NEW    = 3'd1;
  localparam logic [2:0] ST_NODATA = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_STOP   = 3'd4;
  localparam logic [2:0] ST_LEN    = 3'd5;
  localparam logic [2:0] ST_STALE  = 3'd6;

  // Parser phases.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_OVER  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;
  localparam logic [2:0] PH_STOP  = 3'd6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY    = 2'd1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd50;
  localparam logic [7:0]  POLY_RESET    = 8'h9B;

  // Bit 8 set means no marked position is pending.
  localparam logic [8:0] NO_MARK = 9'h100;

  typedef logic [7:0] byte_t;

  // One byte of an MSB-first CRC-8 with no final xor.
  function automatic byte_t crc8_step(input byte_t crc, input byte_t data, input byte_t poly);
    byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/framed_packet_receiver.sv
// Top level of the framed packet receiver: parser, payload store and result pipeline.
`timescale 1ns / 1ps

// Parses a byte stream framed as 0xAA, id, overhead, length, payload, CRC-8 and 0xBB,
// unstuffing the payload into a 256-byte store as it arrives. Each beat on the input
// channel yields exactly one result beat. One item is taken per cycle unless in_stall is high;
// each result passes through a result stage, beside the store's registered read, and then an
// output register. The store is a single RAM with one write and one read port: payload bytes
// write it, read items read it, so no two accesses fall in the same cycle. The store has no
// reset; reading a position never written returns an undefined byte. Configuration writes are
// always ready and must only be issued while the block is idle.
module framed_packet_receiver
  import fpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_rx_byte,
  input  logic [31:0]          in_now_ticks,
  input  logic [7:0]           in_read_index,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [7:0]           out_bytes_read,
  output logic [7:0]           out_packet_id,
  output logic [7:0]           out_read_data,
  // Configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Configuration
  logic [31:0] timeout_r;
  logic [7:0]  poly_r;

  // Parser state
  logic [2:0]  phase_r, phase_nxt;
  logic        active_r, active_nxt;
  logic [31:0] start_r, start_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  overhead_r, overhead_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [8:0]  mark_r, mark_nxt;
  logic [7:0]  crc_r, crc_nxt;

  // Store access
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [7:0]        st_wdata;
  logic [7:0]        st_rdata;

  // Result stage beside the store read, then the output register
  logic       s1_valid_r;
  logic [2:0] s1_status_r;
  logic [7:0] s1_bytes_r;
  logic [7:0] s1_id_r;
  logic       s1_rd_r;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [7:0] out_bytes_r;
  logic [7:0] out_id_r;
  logic [7:0] out_data_r;

  logic       in_acc, out_load;
  logic [2:0] status_nxt;
  logic [7:0] bytes_nxt;
  logic       is_read, rd_in_range;
  logic [31:0] age;
  logic [8:0]  chain_nxt;
  logic [7:0]  pos_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      poly_r    <= POLY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end else if (cfg_index == REG_POLY) begin
        poly_r <= cfg_data[7:0];
      end
    end
  end

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign is_read     = (in_cmd == CMD_READ);
  assign rd_in_range = ({1'b0, in_read_index} < 9'(BUFFER_DEPTH));
  assign age         = in_now_ticks - start_r;
  assign chain_nxt   = {1'b0, pos_r} + {1'b0, in_rx_byte};
  assign pos_inc     = pos_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    active_nxt   = active_r;
    start_nxt    = start_r;
    id_nxt       = id_r;
    overhead_nxt = overhead_r;
    length_nxt   = length_r;
    pos_nxt      = pos_r;
    mark_nxt     = mark_r;
    crc_nxt      = crc_r;
    status_nxt   = ST_NODATA;
    bytes_nxt    = 8'd0;
    st_we        = 1'b0;
    st_waddr     = pos_r[ADDR_W-1:0];
    st_wdata     = in_rx_byte;

    if (is_read) begin
      status_nxt = ST_NODATA;
    end else if (active_r && (age >= timeout_r)) begin
      phase_nxt  = PH_START;
      active_nxt = 1'b0;
      status_nxt = ST_STALE;
    end else if (in_cmd == CMD_BYTE) begin
      status_nxt = ST_CONT;
      unique case (phase_r)
        PH_START: begin
          if (in_rx_byte == FRAME_HEAD) begin
            phase_nxt  = PH_ID;
            active_nxt = 1'b1;
            start_nxt  = in_now_ticks;
          end
        end
        PH_ID: begin
          id_nxt    = in_rx_byte;
          phase_nxt = PH_OVER;
        end
        PH_OVER: begin
          overhead_nxt = in_rx_byte;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          if (in_rx_byte == 8'd0 || {1'b0, in_rx_byte} > 9'(BUFFER_DEPTH)) begin
            phase_nxt  = PH_START;
            active_nxt = 1'b0;
            status_nxt = ST_LEN;
          end else begin
            length_nxt = in_rx_byte;
            pos_nxt    = 8'd0;
            crc_nxt    = 8'd0;
            if (overhead_r != NO_STUFF && overhead_r < in_rx_byte) begin
              mark_nxt = {1'b0, overhead_r};
            end else begin
              mark_nxt = NO_MARK;
            end
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          crc_nxt = crc8_step(crc_r, in_rx_byte, poly_r);
          // A marked byte is restored to the start byte and carries the step to the next mark.
          if (mark_r == {1'b0, pos_r}) begin
            st_wdata = FRAME_HEAD;
            if (in_rx_byte == 8'd0 || chain_nxt >= {1'b0, length_r}) begin
              mark_nxt = NO_MARK;
            end else begin
              mark_nxt = chain_nxt;
            end
          end
          st_we   = ({1'b0, pos_r} < 9'(BUFFER_DEPTH));
          pos_nxt = pos_inc;
          if (pos_inc >= length_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (crc_r != in_rx_byte) begin
            phase_nxt  = PH_START;
            active_nxt = 1'b0;
            status_nxt = ST_CRC;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_STOP: begin
          phase_nxt  = PH_START;
          active_nxt = 1'b0;
          if (in_rx_byte == FRAME_TAIL) begin
            status_nxt = ST_NEW;
            bytes_nxt  = length_r;
          end else begin
            status_nxt = ST_STOP;
          end
        end
        default: begin
          phase_nxt  = PH_START;
          active_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      active_r   <= 1'b0;
      start_r    <= 32'd0;
      id_r       <= 8'd0;
      overhead_r <= 8'd0;
      length_r   <= 8'd0;
      pos_r      <= 8'd0;
      mark_r     <= NO_MARK;
      crc_r      <= 8'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      active_r   <= active_nxt;
      start_r    <= start_nxt;
      id_r       <= id_nxt;
      overhead_r <= overhead_nxt;
      length_r   <= length_nxt;
      pos_r      <= pos_nxt;
      mark_r     <= mark_nxt;
      crc_r      <= crc_nxt;
    end
  end

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (in_acc && st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .re      (in_acc && is_read),
    .raddr   (in_read_index[ADDR_W-1:0]),
    .rdata_r (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= status_nxt;
      s1_bytes_r  <= bytes_nxt;
      s1_id_r     <= id_nxt;
      s1_rd_r     <= is_read && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= s1_status_r;
      out_bytes_r  <= s1_bytes_r;
      out_id_r     <= s1_id_r;
      out_data_r   <= s1_rd_r ? st_rdata : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_bytes_read = out_bytes_r;
  assign out_packet_id  = out_id_r;
  assign out_read_data  = out_data_r;

endmodule

>>> sv/fpr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
